### rtl/core/bpa_pkg.sv
// Shared constants, codes and helper functions of the buddy page allocator.
package bpa_pkg;

  localparam int MAX_PAGES = 1024;
  localparam int TOP_RANK  = 16;
  localparam int PW        = $clog2(MAX_PAGES);  // page index width
  localparam int LW        = PW + 1;             // link width, holds the empty marker
  localparam int XW        = 17;                 // extended page arithmetic width
  localparam int RW        = 5;                  // rank width
  localparam int VW        = 6;                  // page rank entry width

  localparam logic [LW-1:0] EMPTY_MARK = LW'(MAX_PAGES);
  localparam logic [VW-1:0] ALLOC_FLAG = 6'h20;

  localparam logic [2:0] OP_INIT  = 3'd0;
  localparam logic [2:0] OP_ALLOC = 3'd1;
  localparam logic [2:0] OP_FREE  = 3'd2;
  localparam logic [2:0] OP_QRANK = 3'd3;
  localparam logic [2:0] OP_QCNT  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVAL   = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;

  // Control for the free list head and count registers.
  typedef struct packed {
    logic          clr_all;
    logic          init_set;
    logic [RW-1:0] init_rk;
    logic          head_we;
    logic [LW-1:0] head_val;
    logic          cnt_inc;
    logic          cnt_dec;
  } lst_ctl_t;

  // Number of pages spanned by a block of the given rank.
  function automatic logic [XW-1:0] span(input logic [RW-1:0] r);
    logic [RW-1:0] sh;
    sh = r - RW'(1);
    return XW'(1) << sh;
  endfunction

  // Largest rank whose span fits in n pages (n is at least one).
  function automatic logic [RW-1:0] rank_fit(input logic [LW-1:0] n);
    logic [RW-1:0] m;
    m = RW'(1);
    for (int i = 0; i < LW; i++) begin
      if (n[i]) begin
        m = RW'(i + 1);
      end
    end
    return m;
  endfunction

endpackage

### rtl/core/bpa_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module bpa_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/core/buddy_page_allocator_unit.sv
// Buddy page allocator: request sequencer, free list registers and page memories.
//
// One request is taken when start_i is high and busy_o is low; its single result
// appears on the result ports for exactly one cycle with done_o high, and the
// receiver cannot stall it. One sequencer handles every request, walking the page
// rank and link memories one entry at a time: a query reads one page rank entry or
// one list count; allocate searches the lists rank by rank, pops a block, pushes the
// upper half at each split level and marks the pages (at most the popped block's
// size); free checks the block's pages and marks them, then at each merge level checks
// the buddy's pages, unlinks the buddy by walking its list and marks the merged block.
// Init rewrites all 1024 page rank entries; the same pass runs after reset. busy_o
// stays high meanwhile.
module buddy_page_allocator_unit
  import bpa_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  logic [2:0]    opcode_i,
  input  logic [RW-1:0] req_rank_i,
  input  logic [PW-1:0] page_addr_i,
  input  logic          cfg_we_i,
  input  logic [LW-1:0] cfg_wdata_i,
  output logic          done_o,
  output logic [1:0]    status_o,
  output logic [PW-1:0] block_page_o,
  output logic [LW-1:0] answer_o
);

  typedef enum logic [23:0] {
    S_CLR      = 24'h000001,
    S_IDLE     = 24'h000002,
    S_QR       = 24'h000004,
    S_QC       = 24'h000008,
    S_AL_SRCH  = 24'h000010,
    S_AL_POP   = 24'h000020,
    S_AL_SPLIT = 24'h000040,
    S_AL_PUSH  = 24'h000080,
    S_AL_FIN   = 24'h000100,
    S_MARK     = 24'h000200,
    S_FR_V     = 24'h000400,
    S_FR_CHK   = 24'h000800,
    S_FR_CHKW  = 24'h001000,
    S_MG_TOP   = 24'h002000,
    S_MG_CHK   = 24'h004000,
    S_MG_CHKW  = 24'h008000,
    S_UL_H     = 24'h010000,
    S_UL_POP   = 24'h020000,
    S_UL_WALK  = 24'h040000,
    S_UL_CMP   = 24'h080000,
    S_UL_FIX   = 24'h100000,
    S_MG_UP    = 24'h200000,
    S_PUSH_END = 24'h400000,
    S_DONE     = 24'h800000
  } state_e;

  state_e state_q, state_d, mk_ret_q, mk_ret_d;

  logic [LW-1:0] pool_q, psize_q, psize_d;
  logic [RW-1:0] rnk_q, rnk_d, rk_q, rk_d;
  logic [XW-1:0] blk_q, blk_d, bp_q, bp_d, bud_q, bud_d, idx_q, idx_d;
  logic [XW-1:0] mk_ptr_q, mk_ptr_d, mk_end_q, mk_end_d;
  logic [VW-1:0] mk_val_q, mk_val_d, val_q, val_d;
  logic [LW-1:0] cur_q, cur_d, grd_q, grd_d;
  logic [1:0]    st_q, st_d;
  logic [PW-1:0] pg_q, pg_d;
  logic [LW-1:0] an_q, an_d;

  logic [LW-1:0] head_q [TOP_RANK+1];
  logic [LW-1:0] cnt_q  [TOP_RANK+1];
  lst_ctl_t      lst;

  logic          pr_we, nl_we;
  logic [PW-1:0] pr_waddr, pr_raddr, nl_waddr, nl_raddr;
  logic [VW-1:0] pr_wdata, pr_rdata;
  logic [LW-1:0] nl_wdata, nl_rdata;

  logic [LW-1:0] head_sel, cnt_sel, n_sat;
  logic [RW-1:0] m_fit;
  logic [XW-1:0] sum_a, bud_x;

  // Page rank and next link memories.
  bpa_ram #(.DEPTH(MAX_PAGES), .WIDTH(VW)) u_page_rank (
    .clk_i   (clk_i),
    .we_i    (pr_we),
    .waddr_i (pr_waddr),
    .wdata_i (pr_wdata),
    .raddr_i (pr_raddr),
    .rdata_o (pr_rdata)
  );

  bpa_ram #(.DEPTH(MAX_PAGES), .WIDTH(LW)) u_next_link (
    .clk_i   (clk_i),
    .we_i    (nl_we),
    .waddr_i (nl_waddr),
    .wdata_i (nl_wdata),
    .raddr_i (nl_raddr),
    .rdata_o (nl_rdata)
  );

  // Head and count of the list selected by the current rank.
  assign head_sel = (rk_q <= RW'(TOP_RANK)) ? head_q[rk_q] : EMPTY_MARK;
  assign cnt_sel  = (rk_q <= RW'(TOP_RANK)) ? cnt_q[rk_q] : '0;
  assign n_sat    = (pool_q > LW'(MAX_PAGES)) ? LW'(MAX_PAGES) : pool_q;
  assign m_fit    = rank_fit(n_sat);
  assign sum_a    = blk_q + idx_q;
  assign bud_x    = blk_q ^ bp_q;

  // Request sequencer.
  always_comb begin
    state_d  = state_q;
    mk_ret_d = mk_ret_q;
    psize_d  = psize_q;
    rnk_d    = rnk_q;
    rk_d     = rk_q;
    blk_d    = blk_q;
    bp_d     = bp_q;
    bud_d    = bud_q;
    idx_d    = idx_q;
    mk_ptr_d = mk_ptr_q;
    mk_end_d = mk_end_q;
    mk_val_d = mk_val_q;
    val_d    = val_q;
    cur_d    = cur_q;
    grd_d    = grd_q;
    st_d     = st_q;
    pg_d     = pg_q;
    an_d     = an_q;
    lst      = '0;
    pr_we    = 1'b0;
    pr_waddr = mk_ptr_q[PW-1:0];
    pr_wdata = mk_val_q;
    pr_raddr = '0;
    nl_we    = 1'b0;
    nl_waddr = '0;
    nl_wdata = head_sel;
    nl_raddr = '0;

    case (state_q)
      // Rewrite every page rank entry: the initial block gets its rank, the rest zero.
      S_CLR: begin
        pr_we    = 1'b1;
        pr_wdata = (mk_ptr_q < bp_q) ? mk_val_q : '0;
        mk_ptr_d = mk_ptr_q + XW'(1);
        if (mk_ptr_q == XW'(MAX_PAGES - 1)) begin
          state_d = mk_ret_q;
        end
      end

      S_IDLE: begin
        if (start_i) begin
          rnk_d   = req_rank_i;
          blk_d   = XW'(page_addr_i);
          st_d    = ST_INVAL;
          pg_d    = '0;
          an_d    = '0;
          state_d = S_DONE;
          case (opcode_i)
            OP_INIT: begin
              if (pool_q != '0) begin
                psize_d      = n_sat;
                lst.clr_all  = 1'b1;
                lst.init_set = 1'b1;
                lst.init_rk  = m_fit;
                nl_we        = 1'b1;
                nl_waddr     = '0;
                nl_wdata     = EMPTY_MARK;
                bp_d         = span(m_fit);
                mk_val_d     = VW'(m_fit);
                mk_ptr_d     = '0;
                mk_ret_d     = S_DONE;
                st_d         = ST_OK;
                state_d      = S_CLR;
              end
            end
            OP_ALLOC: begin
              if (req_rank_i >= RW'(1) && req_rank_i <= RW'(TOP_RANK)) begin
                rk_d    = req_rank_i;
                state_d = S_AL_SRCH;
              end
            end
            OP_FREE: begin
              if (LW'(page_addr_i) < psize_q) begin
                pr_raddr = page_addr_i;
                state_d  = S_FR_V;
              end
            end
            OP_QRANK: begin
              if (LW'(page_addr_i) < psize_q) begin
                pr_raddr = page_addr_i;
                state_d  = S_QR;
              end
            end
            OP_QCNT: begin
              if (req_rank_i >= RW'(1) && req_rank_i <= RW'(TOP_RANK)) begin
                rk_d    = req_rank_i;
                state_d = S_QC;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_QR: begin
        st_d    = ST_OK;
        an_d    = LW'(pr_rdata[RW-1:0]);
        state_d = S_DONE;
      end

      S_QC: begin
        st_d    = ST_OK;
        an_d    = cnt_sel;
        state_d = S_DONE;
      end

      // Find the smallest non-empty list at or above the requested rank.
      S_AL_SRCH: begin
        if (rk_q > RW'(TOP_RANK)) begin
          st_d    = ST_NOSPACE;
          state_d = S_DONE;
        end else if (head_sel < EMPTY_MARK) begin
          blk_d    = XW'(head_sel);
          nl_raddr = head_sel[PW-1:0];
          state_d  = S_AL_POP;
        end else begin
          rk_d = rk_q + RW'(1);
        end
      end

      S_AL_POP: begin
        lst.head_we  = 1'b1;
        lst.head_val = nl_rdata;
        lst.cnt_dec  = 1'b1;
        state_d      = S_AL_SPLIT;
      end

      // Split down, or mark the allocated block once the rank is reached.
      S_AL_SPLIT: begin
        if (rk_q > rnk_q) begin
          rk_d    = rk_q - RW'(1);
          state_d = S_AL_PUSH;
        end else begin
          mk_ptr_d = blk_q;
          mk_end_d = blk_q + span(rnk_q);
          mk_val_d = ALLOC_FLAG | VW'(rnk_q);
          mk_ret_d = S_AL_FIN;
          state_d  = S_MARK;
        end
      end

      // Push the upper half onto its list and mark its pages.
      S_AL_PUSH: begin
        bud_d = blk_q + span(rk_q);
        if (bud_d < XW'(MAX_PAGES)) begin
          nl_we        = 1'b1;
          nl_waddr     = bud_d[PW-1:0];
          lst.head_we  = 1'b1;
          lst.head_val = bud_d[LW-1:0];
          lst.cnt_inc  = 1'b1;
        end
        mk_ptr_d = bud_d;
        mk_end_d = bud_d + span(rk_q);
        mk_val_d = VW'(rk_q);
        mk_ret_d = S_AL_SPLIT;
        state_d  = S_MARK;
      end

      S_AL_FIN: begin
        st_d    = ST_OK;
        pg_d    = blk_q[PW-1:0];
        state_d = S_DONE;
      end

      // Page marking unit shared by allocate and free.
      S_MARK: begin
        if (mk_ptr_q == mk_end_q) begin
          state_d = mk_ret_q;
        end else begin
          pr_we    = (mk_ptr_q < XW'(MAX_PAGES));
          mk_ptr_d = mk_ptr_q + XW'(1);
        end
      end

      // Check the freed page's entry: allocated, valid rank, block aligned.
      S_FR_V: begin
        val_d = pr_rdata;
        if (!pr_rdata[VW-1] || pr_rdata[RW-1:0] < RW'(1) ||
            pr_rdata[RW-1:0] > RW'(TOP_RANK)) begin
          state_d = S_DONE;
        end else if ((blk_q & (span(pr_rdata[RW-1:0]) - XW'(1))) != '0) begin
          state_d = S_DONE;
        end else begin
          rk_d    = pr_rdata[RW-1:0];
          bp_d    = span(pr_rdata[RW-1:0]);
          idx_d   = '0;
          state_d = S_FR_CHK;
        end
      end

      S_FR_CHK: begin
        if (idx_q == bp_q) begin
          mk_ptr_d = blk_q;
          mk_end_d = blk_q + bp_q;
          mk_val_d = VW'(rk_q);
          mk_ret_d = S_MG_TOP;
          state_d  = S_MARK;
        end else if (sum_a >= XW'(MAX_PAGES)) begin
          state_d = S_DONE;
        end else begin
          pr_raddr = sum_a[PW-1:0];
          state_d  = S_FR_CHKW;
        end
      end

      S_FR_CHKW: begin
        if (pr_rdata != val_q) begin
          state_d = S_DONE;
        end else begin
          idx_d   = idx_q + XW'(1);
          state_d = S_FR_CHK;
        end
      end

      // Merge loop: stop at the top rank, else check whether the buddy lies inside the pool.
      S_MG_TOP: begin
        if (rk_q >= RW'(TOP_RANK)) begin
          state_d = S_PUSH_END;
        end else if (bud_x + bp_q > XW'(psize_q)) begin
          state_d = S_PUSH_END;
        end else begin
          bud_d   = bud_x;
          idx_d   = '0;
          state_d = S_MG_CHK;
        end
      end

      S_MG_CHK: begin
        if (idx_q == bp_q) begin
          state_d = S_UL_H;
        end else begin
          pr_raddr = PW'(bud_q + idx_q);
          state_d  = S_MG_CHKW;
        end
      end

      S_MG_CHKW: begin
        if (pr_rdata != VW'(rk_q)) begin
          state_d = S_PUSH_END;
        end else begin
          idx_d   = idx_q + XW'(1);
          state_d = S_MG_CHK;
        end
      end

      // Unlink the buddy from its list, from the head or by walking the links.
      S_UL_H: begin
        if (XW'(head_sel) == bud_q) begin
          nl_raddr = bud_q[PW-1:0];
          state_d  = S_UL_POP;
        end else begin
          cur_d   = head_sel;
          grd_d   = '0;
          state_d = S_UL_WALK;
        end
      end

      S_UL_POP: begin
        lst.head_we  = 1'b1;
        lst.head_val = nl_rdata;
        lst.cnt_dec  = 1'b1;
        state_d      = S_MG_UP;
      end

      S_UL_WALK: begin
        if (grd_q < LW'(MAX_PAGES) && cur_q < EMPTY_MARK) begin
          nl_raddr = cur_q[PW-1:0];
          state_d  = S_UL_CMP;
        end else begin
          state_d = S_MG_UP;
        end
      end

      S_UL_CMP: begin
        if (XW'(nl_rdata) == bud_q) begin
          nl_raddr = bud_q[PW-1:0];
          state_d  = S_UL_FIX;
        end else begin
          cur_d   = nl_rdata;
          grd_d   = grd_q + LW'(1);
          state_d = S_UL_WALK;
        end
      end

      S_UL_FIX: begin
        nl_we       = 1'b1;
        nl_waddr    = cur_q[PW-1:0];
        nl_wdata    = nl_rdata;
        lst.cnt_dec = 1'b1;
        state_d     = S_MG_UP;
      end

      // Step up one rank and mark the merged block.
      S_MG_UP: begin
        if (bud_q < blk_q) begin
          blk_d = bud_q;
        end
        rk_d     = rk_q + RW'(1);
        bp_d     = span(rk_d);
        mk_ptr_d = blk_d;
        mk_end_d = blk_d + bp_d;
        mk_val_d = VW'(rk_d);
        mk_ret_d = S_MG_TOP;
        state_d  = S_MARK;
      end

      S_PUSH_END: begin
        if (blk_q < XW'(MAX_PAGES)) begin
          nl_we        = 1'b1;
          nl_waddr     = blk_q[PW-1:0];
          lst.head_we  = 1'b1;
          lst.head_val = blk_q[LW-1:0];
          lst.cnt_inc  = 1'b1;
        end
        st_d    = ST_OK;
        state_d = S_DONE;
      end

      S_DONE: begin
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Sequencer control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      mk_ret_q <= S_IDLE;
      mk_ptr_q <= '0;
      bp_q     <= '0;
      psize_q  <= '0;
      pool_q   <= LW'(MAX_PAGES);
    end else begin
      state_q  <= state_d;
      mk_ret_q <= mk_ret_d;
      mk_ptr_q <= mk_ptr_d;
      bp_q     <= bp_d;
      psize_q  <= psize_d;
      if (cfg_we_i) begin
        pool_q <= cfg_wdata_i;
      end
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    rnk_q    <= rnk_d;
    rk_q     <= rk_d;
    blk_q    <= blk_d;
    bud_q    <= bud_d;
    idx_q    <= idx_d;
    mk_end_q <= mk_end_d;
    mk_val_q <= mk_val_d;
    val_q    <= val_d;
    cur_q    <= cur_d;
    grd_q    <= grd_d;
    st_q     <= st_d;
    pg_q     <= pg_d;
    an_q     <= an_d;
  end

  // Free list heads and counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= TOP_RANK; i++) begin
        head_q[i] <= EMPTY_MARK;
        cnt_q[i]  <= '0;
      end
    end else if (lst.clr_all) begin
      for (int i = 0; i <= TOP_RANK; i++) begin
        head_q[i] <= EMPTY_MARK;
        cnt_q[i]  <= '0;
      end
      if (lst.init_set) begin
        head_q[lst.init_rk] <= '0;
        cnt_q[lst.init_rk]  <= LW'(1);
      end
    end else if (rk_q <= RW'(TOP_RANK)) begin
      if (lst.head_we) begin
        head_q[rk_q] <= lst.head_val;
      end
      if (lst.cnt_inc) begin
        cnt_q[rk_q] <= cnt_q[rk_q] + LW'(1);
      end else if (lst.cnt_dec && cnt_q[rk_q] != '0) begin
        cnt_q[rk_q] <= cnt_q[rk_q] - LW'(1);
      end
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = (state_q == S_DONE);
  assign status_o     = st_q;
  assign block_page_o = pg_q;
  assign answer_o     = an_q;

`ifndef ASSERT_OFF
  // An accepted request makes the block busy in the next cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("request accepted but block not busy");

  // After a result the block is ready again.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o && !done_o) else $error("block not ready after result");

  // A failed request returns zero page and answer.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> block_page_o == '0 && answer_o == '0)
    else $error("failed request carries data");
`endif

endmodule

### verif/buddy_page_allocator_unit_tb.sv
// Self-checking testbench for the buddy page allocator with a built-in predictor.
`timescale 1ns / 100ps

module buddy_page_allocator_unit_tb
  import bpa_pkg::*;
();

  localparam int WATCHDOG_CYCLES = 60000;
  localparam int DRAIN_CYCLES    = 1100;

  typedef struct packed {
    logic [1:0]    status;
    logic [PW-1:0] block_page;
    logic [LW-1:0] answer;
  } alloc_result_t;

  logic          clk_i;
  logic          rst_ni;
  logic          start_i;
  logic          busy_o;
  logic [2:0]    opcode_i;
  logic [RW-1:0] req_rank_i;
  logic [PW-1:0] page_addr_i;
  logic          cfg_we_i;
  logic [LW-1:0] cfg_wdata_i;
  logic          done_o;
  logic [1:0]    status_o;
  logic [PW-1:0] block_page_o;
  logic [LW-1:0] answer_o;

  buddy_page_allocator_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .opcode_i    (opcode_i),
    .req_rank_i  (req_rank_i),
    .page_addr_i (page_addr_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .block_page_o(block_page_o),
    .answer_o    (answer_o)
  );

  // Shadow copy of the allocator state.
  logic [VW-1:0] shadow_rank [MAX_PAGES];
  int unsigned   shadow_link [MAX_PAGES];
  int unsigned   shadow_head [TOP_RANK+1];
  int unsigned   shadow_count[TOP_RANK+1];
  int unsigned   shadow_cfg;
  int unsigned   shadow_pool;

  alloc_result_t expected_results[$];
  int unsigned   live_blocks[$];
  int            mismatch_count;
  int            idle_cycles;
  bit            request_taken;

  always #4 clk_i = ~clk_i;

  function automatic int unsigned pages_of(int unsigned r);
    return 32'd1 << ((r - 1) & 31);
  endfunction

  task automatic shadow_clear();
    for (int i = 0; i < MAX_PAGES; i++) begin
      shadow_rank[i] = '0;
      shadow_link[i] = 0;
    end
    for (int r = 0; r <= TOP_RANK; r++) begin
      shadow_head[r]  = MAX_PAGES;
      shadow_count[r] = 0;
    end
  endtask

  task automatic shadow_mark(int unsigned first, int unsigned n, logic [VW-1:0] v);
    for (int unsigned i = 0; i < n; i++) begin
      if (first + i < MAX_PAGES) shadow_rank[first + i] = v;
    end
  endtask

  task automatic shadow_push(int unsigned r, int unsigned b);
    if (b < MAX_PAGES) begin
      shadow_link[b]  = shadow_head[r];
      shadow_head[r]  = b;
      shadow_count[r] = (shadow_count[r] + 1) & 11'h7ff;
    end
  endtask

  task automatic shadow_pop(int unsigned r, output int unsigned b);
    b = shadow_head[r];
    if (b < MAX_PAGES) begin
      shadow_head[r] = shadow_link[b];
      if (shadow_count[r] > 0) shadow_count[r]--;
    end else begin
      b = MAX_PAGES;
    end
  endtask

  task automatic shadow_unlink(int unsigned r, int unsigned b);
    int unsigned cur;
    int unsigned nx;
    int unsigned dummy;
    if (shadow_head[r] == b) begin
      shadow_pop(r, dummy);
    end else begin
      cur = shadow_head[r];
      for (int g = 0; g < MAX_PAGES && cur < MAX_PAGES; g++) begin
        nx = shadow_link[cur];
        if (nx == b) begin
          shadow_link[cur] = (b < MAX_PAGES) ? shadow_link[b] : MAX_PAGES;
          if (shadow_count[r] > 0) shadow_count[r]--;
          break;
        end
        cur = nx;
      end
    end
  endtask

  task automatic predict_free(int unsigned p, output logic [1:0] st);
    logic [VW-1:0] v;
    int unsigned   r;
    int unsigned   bp;
    int unsigned   first;
    int unsigned   bud;
    bit            whole;
    st = ST_INVAL;
    if (p >= shadow_pool) return;
    v = shadow_rank[p];
    if (!v[5]) return;
    r = v[4:0];
    if (r < 1 || r > TOP_RANK) return;
    bp = pages_of(r);
    if ((p & (bp - 1)) != 0) return;
    for (int unsigned i = 0; i < bp; i++) begin
      if (p + i >= MAX_PAGES || shadow_rank[p + i] != v) return;
    end
    shadow_mark(p, bp, VW'(r));
    first = p;
    // Merge upward while the whole buddy is free at the same rank.
    while (r < TOP_RANK) begin
      bud = first ^ bp;
      if (bud + bp > shadow_pool) break;
      whole = 1'b1;
      for (int unsigned i = 0; i < bp; i++) begin
        if (bud + i >= MAX_PAGES || shadow_rank[bud + i] != VW'(r)) begin
          whole = 1'b0;
          break;
        end
      end
      if (!whole) break;
      shadow_unlink(r, bud);
      if (bud < first) first = bud;
      r++;
      bp = pages_of(r);
      shadow_mark(first, bp, VW'(r));
    end
    shadow_push(r, first);
    st = ST_OK;
  endtask

  // Computes the result of one request and updates the shadow state.
  task automatic predict_request(logic [2:0] op, logic [RW-1:0] rk, logic [PW-1:0] pa);
    alloc_result_t res;
    int unsigned   n;
    int unsigned   m;
    int unsigned   cur;
    int unsigned   b;
    res = '{status: ST_INVAL, block_page: '0, answer: '0};
    case (op)
      OP_INIT: begin
        n = shadow_cfg;
        if (n != 0) begin
          if (n > MAX_PAGES) n = MAX_PAGES;
          shadow_clear();
          shadow_pool = n;
          m = 1;
          while (m < TOP_RANK && pages_of(m + 1) <= n) m++;
          shadow_push(m, 0);
          shadow_mark(0, pages_of(m), VW'(m));
          live_blocks.delete();
          res.status = ST_OK;
        end
      end
      OP_ALLOC: begin
        if (rk >= 1 && rk <= TOP_RANK) begin
          cur = rk;
          while (cur <= TOP_RANK && shadow_head[cur] >= MAX_PAGES) cur++;
          if (cur > TOP_RANK) begin
            res.status = ST_NOSPACE;
          end else begin
            shadow_pop(cur, b);
            // Split down, pushing each upper half.
            while (cur > rk) begin
              cur--;
              shadow_push(cur, b + pages_of(cur));
              shadow_mark(b + pages_of(cur), pages_of(cur), VW'(cur));
            end
            shadow_mark(b, pages_of(rk), ALLOC_FLAG | VW'(rk));
            res.status     = ST_OK;
            res.block_page = PW'(b);
            live_blocks.push_back(b);
          end
        end
      end
      OP_FREE: predict_free(pa, res.status);
      OP_QRANK: begin
        if (pa < shadow_pool) begin
          res.status = ST_OK;
          res.answer = LW'(shadow_rank[pa][4:0]);
        end
      end
      OP_QCNT: begin
        if (rk >= 1 && rk <= TOP_RANK) begin
          res.status = ST_OK;
          res.answer = LW'(shadow_count[rk]);
        end
      end
      default: res.status = ST_INVAL;
    endcase
    expected_results.push_back(res);
  endtask

  function automatic int unsigned random_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    return $urandom_range(0, 3);
  endfunction

  // Sends one request; start stays high afterwards so back-to-back requests work.
  task automatic send_request(logic [2:0] op, logic [RW-1:0] rk, logic [PW-1:0] pa,
                              int unsigned gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    opcode_i    <= op;
    req_rank_i  <= rk;
    page_addr_i <= pa;
    forever begin
      @(negedge clk_i);
      if (!busy_o) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    request_taken = 1'b1;
    predict_request(op, rk, pa);
  endtask

  task automatic send_gapped(logic [2:0] op, logic [RW-1:0] rk, logic [PW-1:0] pa);
    send_request(op, rk, pa, random_gap());
  endtask

  // Waits until every expected result has arrived and the block is idle.
  task automatic drain();
    start_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    forever begin
      @(negedge clk_i);
      if (!busy_o) break;
    end
    @(posedge clk_i);
  endtask

  task automatic write_pool(int unsigned pages);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= LW'(pages);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_cfg = pages & 11'h7ff;
  endtask

  task automatic test_before_init();
    send_gapped(OP_ALLOC, 5'd1, '0);
    send_gapped(OP_FREE, 5'd0, '0);
    send_gapped(OP_QRANK, 5'd0, '0);
    send_gapped(OP_QCNT, 5'd1, '0);
    send_gapped(OP_QCNT, 5'd0, '0);
    send_gapped(OP_ALLOC, 5'd0, 10'h3ff);
    send_gapped(3'd5, 5'd31, 10'h3ff);
    send_gapped(3'd6, 5'd17, '0);
    send_gapped(3'd7, 5'd16, 10'h155);
  endtask

  task automatic test_pool_extremes();
    write_pool(0);
    send_gapped(OP_INIT, '0, '0);
    write_pool(1);
    send_gapped(OP_INIT, '0, '0);
    send_gapped(OP_ALLOC, 5'd2, '0);
    send_gapped(OP_ALLOC, 5'd1, '0);
    send_gapped(OP_ALLOC, 5'd1, '0);
    send_gapped(OP_QRANK, '0, 10'd1);
    send_gapped(OP_FREE, '0, '0);
    send_gapped(OP_QCNT, 5'd1, '0);
    write_pool(2047);
    send_gapped(OP_INIT, '0, '0);
    send_gapped(OP_QCNT, 5'd11, '0);
  endtask

  task automatic test_bad_frees();
    write_pool(1024);
    send_gapped(OP_INIT, '0, '0);
    send_gapped(OP_ALLOC, 5'd16, '0);
    send_gapped(OP_ALLOC, 5'd17, '0);
    send_gapped(OP_ALLOC, 5'd3, '0);
    send_gapped(OP_FREE, '0, 10'd1);
    send_gapped(OP_FREE, '0, 10'd512);
    send_gapped(OP_QRANK, '0, 10'd1023);
    send_gapped(OP_FREE, '0, '0);
    send_gapped(OP_FREE, '0, '0);
    live_blocks.delete();
    send_gapped(OP_ALLOC, 5'd11, '0);
    send_gapped(OP_QRANK, '0, 10'd0);
    send_gapped(OP_FREE, '0, '0);
  endtask

  // Random phase: mostly allocate and free of live blocks, some queries and noise.
  task automatic test_random_phase(int unsigned pages, int unsigned count);
    int unsigned pick;
    int unsigned idx;
    int unsigned b;
    logic [RW-1:0] rk;
    write_pool(pages);
    send_gapped(OP_INIT, '0, '0);
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      rk = ($urandom_range(0, 7) == 0) ? RW'($urandom_range(1, 11))
                                       : RW'($urandom_range(1, 4));
      if (pick < 45) begin
        send_gapped(OP_ALLOC, rk, PW'($urandom));
      end else if (pick < 80 && live_blocks.size() != 0) begin
        idx = $urandom_range(0, live_blocks.size() - 1);
        b = live_blocks[idx];
        live_blocks.delete(idx);
        send_gapped(OP_FREE, RW'($urandom), PW'(b));
      end else if (pick < 86) begin
        send_gapped(OP_QRANK, RW'($urandom), PW'($urandom_range(0, pages)));
      end else if (pick < 92) begin
        send_gapped(OP_QCNT, RW'($urandom_range(0, 17)), PW'($urandom));
      end else if (pick < 94) begin
        send_gapped(OP_FREE, RW'($urandom), PW'($urandom));
      end else begin
        send_gapped(3'($urandom), RW'($urandom), PW'($urandom));
      end
    end
  endtask

  // Checks each result against the oldest expectation.
  always @(negedge clk_i) begin
    alloc_result_t exp_res;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result: status %0d page %0d answer %0d",
                   status_o, block_page_o, answer_o);
      end else begin
        exp_res = expected_results.pop_front();
        if (status_o !== exp_res.status || block_page_o !== exp_res.block_page ||
            answer_o !== exp_res.answer) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected status %0d page %0d answer %0d, got %0d %0d %0d",
                     exp_res.status, exp_res.block_page, exp_res.answer,
                     status_o, block_page_o, answer_o);
        end
      end
    end
  end

  // Watchdog on cycles with neither a request taken nor a result given.
  always @(posedge clk_i) begin
    if (request_taken || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    request_taken = 1'b0;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("buddy_page_allocator_unit test failed");
      $finish;
    end
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    opcode_i       = '0;
    req_rank_i     = '0;
    page_addr_i    = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    mismatch_count = 0;
    idle_cycles    = 0;
    request_taken  = 1'b0;
    shadow_clear();
    shadow_cfg  = 1024;
    shadow_pool = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_before_init();
    test_pool_extremes();
    test_bad_frees();
    test_random_phase(16, 180);
    test_random_phase(1, 60);
    test_random_phase($urandom_range(3, 100), 180);
    test_random_phase(1024, 150);
    test_random_phase($urandom_range(2, 40), 180);
    test_random_phase(1000, 120);
    test_random_phase($urandom_range(101, 300), 160);
    test_random_phase(2, 80);
    test_random_phase($urandom_range(1025, 2047), 100);
    test_random_phase($urandom_range(5, 64), 100);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("buddy_page_allocator_unit test passed");
    end else begin
      $display("buddy_page_allocator_unit test failed");
    end
    $finish;
  end

endmodule
